/* rtl/tmac_pkg.sv */
// Shared types and constants of the multipole acceptance core.
package tmac_pkg;

   // Decision codes.
   localparam logic [1:0] DEC_ACCEPT       = 2'd0;
   localparam logic [1:0] DEC_SPLIT_SOURCE = 2'd1;
   localparam logic [1:0] DEC_SPLIT_SINK   = 2'd2;

   // Fault codes.
   localparam logic [1:0] FAULT_NONE       = 2'd0;
   localparam logic [1:0] FAULT_BODY_SPLIT = 2'd1;
   localparam logic [1:0] FAULT_OVERFLOW   = 2'd2;

   // Register indexes of the control port.
   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SINK_X            = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SINK_Y            = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SINK_Z            = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SINK_EXTENT       = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SINK_IS_BODY      = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_TEST_MODE         = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_BASE_LIST_COUNT   = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_BASE_INTERACTIONS = 3'd7;

   // Work queue between the classifier and the list stage.
   localparam int QUEUE_DEPTH = 8;
   localparam int QUEUE_IDX_W = 3;
   localparam int QUEUE_CNT_W = 4;

   // One source node as it arrives.
   typedef struct packed {
      logic               first_of_batch;
      logic               source_is_cell;
      logic [31:0]        source_mass;
      logic signed [31:0] source_x;
      logic signed [31:0] source_y;
      logic signed [31:0] source_z;
      logic [30:0]        source_rcrit;
      logic [23:0]        source_daughters;
   } req_type;

   // One result as it leaves.
   typedef struct packed {
      logic [1:0]         decision;
      logic [15:0]        list_slot;
      logic [31:0]        entry_mass;
      logic signed [31:0] entry_x;
      logic signed [31:0] entry_y;
      logic signed [31:0] entry_z;
      logic [16:0]        list_count;
      logic [31:0]        interaction_total;
      logic [1:0]         fault;
   } rsp_type;

   // Configuration registers.
   typedef struct packed {
      logic signed [31:0] sink_x;
      logic signed [31:0] sink_y;
      logic signed [31:0] sink_z;
      logic [30:0]        sink_extent;
      logic               sink_is_body;
      logic               test_mode;
      logic [16:0]        base_list_count;
      logic [31:0]        base_interactions;
   } cfg_type;

   // Register values after reset: everything zero, dual test selected.
   localparam cfg_type CFG_RESET = '{
      sink_x:            32'sd0,
      sink_y:            32'sd0,
      sink_z:            32'sd0,
      sink_extent:       31'd0,
      sink_is_body:      1'b0,
      test_mode:         1'b1,
      base_list_count:   17'd0,
      base_interactions: 32'd0
   };

   // A classified node waiting for the list stage.
   typedef struct packed {
      logic               first_of_batch;
      logic [1:0]         decision;
      logic               body_split;
      logic [23:0]        add_amount;
      logic [31:0]        mass;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
   } work_type;

   // Queue status seen by both sides.
   typedef struct packed {
      logic [QUEUE_CNT_W-1:0] count;
      logic                   head_valid;
   } queue_status_type;

endpackage

/* rtl/tmac_front.sv */
// Front end: accepts source nodes and classifies them against the sink.
module tmac_front #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  tmac_pkg::cfg_type          cfg,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  tmac_pkg::req_type          req_data,
   input  tmac_pkg::queue_status_type qstat,
   output logic                      push_valid,
   output tmac_pkg::work_type         push_data
);

   localparam int SHIFT = 32 - COORD_WIDTH;
   localparam int QUEUE_CNT_W_L = tmac_pkg::QUEUE_CNT_W;

   typedef struct packed {
      logic               first_of_batch;
      logic               is_cell;
      logic [31:0]        mass;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic [23:0]        daughters;
      logic [31:0]        dx;
      logic [31:0]        dy;
      logic [31:0]        dz;
      logic [31:0]        radius;
      logic               ext_big;
   } s1_type;

   typedef struct packed {
      logic               first_of_batch;
      logic               is_cell;
      logic [31:0]        mass;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic [23:0]        daughters;
      logic [63:0]        sq_x;
      logic [63:0]        sq_y;
      logic [63:0]        sq_z;
      logic [63:0]        radius_sq;
      logic               ext_big;
   } s2_type;

   // Keeps the low coordinate bits, sign extended.
   function automatic logic signed [31:0] coord(input logic [31:0] v);
      coord = $signed(v << SHIFT) >>> SHIFT;
   endfunction

   // Magnitude of a coordinate difference; it always fits 32 bits.
   function automatic logic [31:0] absdiff(input logic signed [31:0] a,
                                           input logic signed [31:0] b);
      logic signed [32:0] ae;
      logic signed [32:0] be;
      logic signed [32:0] d;
      ae = {a[31], a};
      be = {b[31], b};
      d  = (a >= b) ? (ae - be) : (be - ae);
      absdiff = d[31:0];
   endfunction

   logic                         s1_valid_ff, s1_valid_in;
   logic                         s2_valid_ff, s2_valid_in;
   s1_type                       s1_ff, s1_in;
   s2_type                       s2_ff, s2_in;
   logic                         accept;
   logic [QUEUE_CNT_W_L-1:0]     occupancy;
   logic [31:0]                  rb;
   logic [32:0]                  ext4;
   logic [65:0]                  dist_sq;
   logic [65:0]                  rsq;
   logic [1:0]                   decision;
   logic                         body_split;

   // Items in flight plus queued items must fit in the queue.
   assign occupancy = qstat.count + QUEUE_CNT_W_L'(s1_valid_ff) + QUEUE_CNT_W_L'(s2_valid_ff);
   assign req_stall = occupancy >= QUEUE_CNT_W_L'(tmac_pkg::QUEUE_DEPTH);
   assign accept    = req_valid && !req_stall;

   // Stage one: differences, combined radius and the extent check.
   always_comb begin
      rb   = {1'b0, req_data.source_rcrit} + {1'b0, cfg.sink_extent};
      ext4 = {cfg.sink_extent, 2'b00};
      s1_in.first_of_batch = req_data.first_of_batch;
      s1_in.is_cell        = req_data.source_is_cell;
      s1_in.mass           = req_data.source_mass;
      s1_in.pos_x          = coord(req_data.source_x);
      s1_in.pos_y          = coord(req_data.source_y);
      s1_in.pos_z          = coord(req_data.source_z);
      s1_in.daughters      = req_data.source_daughters;
      s1_in.dx             = absdiff(coord(req_data.source_x), coord(cfg.sink_x));
      s1_in.dy             = absdiff(coord(req_data.source_y), coord(cfg.sink_y));
      s1_in.dz             = absdiff(coord(req_data.source_z), coord(cfg.sink_z));
      s1_in.radius         = cfg.test_mode ? rb : {1'b0, req_data.source_rcrit};
      s1_in.ext_big        = ext4 > {1'b0, rb};
   end

   // Stage two: the four squares.
   always_comb begin
      s2_in.first_of_batch = s1_ff.first_of_batch;
      s2_in.is_cell        = s1_ff.is_cell;
      s2_in.mass           = s1_ff.mass;
      s2_in.pos_x          = s1_ff.pos_x;
      s2_in.pos_y          = s1_ff.pos_y;
      s2_in.pos_z          = s1_ff.pos_z;
      s2_in.daughters      = s1_ff.daughters;
      s2_in.sq_x           = s1_ff.dx * s1_ff.dx;
      s2_in.sq_y           = s1_ff.dy * s1_ff.dy;
      s2_in.sq_z           = s1_ff.dz * s1_ff.dz;
      s2_in.radius_sq      = s1_ff.radius * s1_ff.radius;
      s2_in.ext_big        = s1_ff.ext_big;
   end

   // Decision: squared distance against squared radius, then the mode rules.
   always_comb begin
      dist_sq = {2'b00, s2_ff.sq_x} + {2'b00, s2_ff.sq_y} + {2'b00, s2_ff.sq_z};
      rsq     = {2'b00, s2_ff.radius_sq};
      decision   = tmac_pkg::DEC_ACCEPT;
      body_split = 1'b0;
      if (!cfg.test_mode) begin
         if (!cfg.sink_is_body) begin
            decision = tmac_pkg::DEC_SPLIT_SINK;
         end else if (s2_ff.is_cell && (dist_sq < rsq)) begin
            decision = tmac_pkg::DEC_SPLIT_SOURCE;
         end
      end else begin
         if (s2_ff.is_cell && !(dist_sq > rsq)) begin
            if (s2_ff.ext_big) begin
               decision   = tmac_pkg::DEC_SPLIT_SINK;
               body_split = cfg.sink_is_body;
            end else begin
               decision = tmac_pkg::DEC_SPLIT_SOURCE;
            end
         end
      end
   end

   // Classified item toward the queue.
   always_comb begin
      push_valid               = s2_valid_ff;
      push_data.first_of_batch = s2_ff.first_of_batch;
      push_data.decision       = decision;
      push_data.body_split     = body_split;
      push_data.add_amount     = s2_ff.is_cell ? s2_ff.daughters : 24'd1;
      push_data.mass           = s2_ff.mass;
      push_data.pos_x          = s2_ff.pos_x;
      push_data.pos_y          = s2_ff.pos_y;
      push_data.pos_z          = s2_ff.pos_z;
   end

   assign s1_valid_in = accept;
   assign s2_valid_in = s1_valid_ff;

   // Stage valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // Stage payloads.
   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
      s2_ff <= s2_in;
   end

endmodule

/* rtl/tmac_queue.sv */
// Short work queue between the classifier and the list stage.
module tmac_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  tmac_pkg::work_type         push_data,
   input  logic                      pop,
   output tmac_pkg::work_type         head_data,
   output tmac_pkg::queue_status_type qstat
);

   localparam int IDX_W = tmac_pkg::QUEUE_IDX_W;
   localparam int CNT_W = tmac_pkg::QUEUE_CNT_W;

   tmac_pkg::work_type entry_ff [tmac_pkg::QUEUE_DEPTH];
   logic [IDX_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [IDX_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   // Pointer and fill updates.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + IDX_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + IDX_W'(1) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head_data        = entry_ff[rd_ptr_ff];
   assign qstat.count      = count_ff;
   assign qstat.head_valid = count_ff != '0;

`ifndef SYNTHESIS
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff < CNT_W'(tmac_pkg::QUEUE_DEPTH)))
      else $error("work queue written while full");
   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> (count_ff != '0))
      else $error("work queue read while empty");
`endif

endmodule

/* rtl/tmac_back.sv */
// Back end: list append, interaction total and the result register.
module tmac_back #(
   parameter int LIST_DEPTH = 65536
) (
   input  logic              clock,
   input  logic              reset,
   input  tmac_pkg::cfg_type  cfg,
   input  logic              head_valid,
   input  tmac_pkg::work_type head_data,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tmac_pkg::rsp_type  rsp_data
);

   localparam int DEPTH_W = $clog2(LIST_DEPTH + 1);
   localparam int CNT_W   = (DEPTH_W > 17) ? DEPTH_W : 17;

   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic [31:0]       total_ff, total_in;
   logic              rsp_valid_ff, rsp_valid_in;
   tmac_pkg::rsp_type rsp_ff, rsp_in;
   logic [CNT_W-1:0]  fill_cur;
   logic [31:0]       total_cur;
   logic [32:0]       total_sum;

   // Take the next item when the result register is free or being taken.
   assign pop = head_valid && (!rsp_valid_ff || !rsp_stall);

   // Counter update and result assembly for the item at the queue head.
   always_comb begin
      fill_cur  = head_data.first_of_batch ? CNT_W'(cfg.base_list_count) : fill_ff;
      total_cur = head_data.first_of_batch ? cfg.base_interactions : total_ff;
      total_sum = {1'b0, total_cur} + 33'(head_data.add_amount);
      fill_in   = fill_cur;
      total_in  = total_cur;

      rsp_in.decision   = head_data.decision;
      rsp_in.list_slot  = '0;
      rsp_in.entry_mass = '0;
      rsp_in.entry_x    = '0;
      rsp_in.entry_y    = '0;
      rsp_in.entry_z    = '0;
      rsp_in.fault      = head_data.body_split ? tmac_pkg::FAULT_BODY_SPLIT
                                               : tmac_pkg::FAULT_NONE;

      if (head_data.decision == tmac_pkg::DEC_ACCEPT) begin
         if (fill_cur >= CNT_W'(LIST_DEPTH)) begin
            rsp_in.fault = tmac_pkg::FAULT_OVERFLOW;
         end else begin
            rsp_in.list_slot  = fill_cur[15:0];
            rsp_in.entry_mass = head_data.mass;
            rsp_in.entry_x    = head_data.pos_x;
            rsp_in.entry_y    = head_data.pos_y;
            rsp_in.entry_z    = head_data.pos_z;
            fill_in           = fill_cur + CNT_W'(1);
            total_in          = total_sum[32] ? 32'hFFFF_FFFF : total_sum[31:0];
         end
      end

      rsp_in.list_count        = fill_in[16:0];
      rsp_in.interaction_total = total_in;
   end

   // Result valid: set on a new beat, cleared once the beat is taken.
   always_comb begin
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            fill_ff  <= fill_in;
            total_ff <= total_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_overflow_is_accept: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.fault == tmac_pkg::FAULT_OVERFLOW) |->
      (rsp_ff.decision == tmac_pkg::DEC_ACCEPT && rsp_ff.list_slot == '0))
      else $error("overflow result carries a list entry");
   a_body_split_is_sink: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.fault == tmac_pkg::FAULT_BODY_SPLIT) |->
      (rsp_ff.decision == tmac_pkg::DEC_SPLIT_SINK))
      else $error("body split fault without a split sink decision");
`endif

endmodule

/* rtl/tree_multipole_acceptance_core.sv */
// Top level of the multipole acceptance core: control registers and datapath.
//
// Usage: write the sink and batch registers on the csr_ port (csr_ready is
// always high) while the core is idle, then stream source nodes on the req_
// channel. Each accepted beat yields exactly one beat on the rsp_ channel, in
// order, with the decision, list slot, entry and the running list fill and
// interaction total. A beat with first_of_batch set reloads both counters
// from the base registers before it is processed.
// A request passes the stage one and two registers, the work queue and the
// result register. Throughput: one beat per cycle while req_stall is low,
// set by the two-stage classifier (differences, then the squares of a 32-bit
// multiplier per axis) feeding an eight-entry work queue that the list stage
// drains once per cycle unless the receiver stalls, when the result register
// holds its beat; the queue absorbs items already in flight and req_stall
// rises once queued and in-flight items fill the queue.
// Reset (synchronous, active high) empties the pipeline and queue, clears the
// counters and returns the registers to their defaults, with the dual test
// selected. No clearing pass follows reset.
module tree_multipole_acceptance_core #(
   parameter int LIST_DEPTH  = 65536,
   parameter int COORD_WIDTH = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  tmac_pkg::req_type                     req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output tmac_pkg::rsp_type                     rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [tmac_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [31:0]                          csr_wdata
);

   tmac_pkg::cfg_type          cfg_ff, cfg_in;
   tmac_pkg::queue_status_type qstat;
   tmac_pkg::work_type         push_data;
   tmac_pkg::work_type         head_data;
   logic                       push_valid;
   logic                       pop;

   assign csr_ready = 1'b1;

   // Register write decode.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            tmac_pkg::CSR_SINK_X:            cfg_in.sink_x            = csr_wdata;
            tmac_pkg::CSR_SINK_Y:            cfg_in.sink_y            = csr_wdata;
            tmac_pkg::CSR_SINK_Z:            cfg_in.sink_z            = csr_wdata;
            tmac_pkg::CSR_SINK_EXTENT:       cfg_in.sink_extent       = csr_wdata[30:0];
            tmac_pkg::CSR_SINK_IS_BODY:      cfg_in.sink_is_body      = csr_wdata[0];
            tmac_pkg::CSR_TEST_MODE:         cfg_in.test_mode         = csr_wdata[0];
            tmac_pkg::CSR_BASE_LIST_COUNT:   cfg_in.base_list_count   = csr_wdata[16:0];
            tmac_pkg::CSR_BASE_INTERACTIONS: cfg_in.base_interactions = csr_wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= tmac_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tmac_front #(
      .COORD_WIDTH(COORD_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .qstat      (qstat),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   tmac_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_data (push_data),
      .pop       (pop),
      .head_data (head_data),
      .qstat     (qstat)
   );

   tmac_back #(
      .LIST_DEPTH(LIST_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head_valid (qstat.head_valid),
      .head_data  (head_data),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

/* dv/tb.sv */
// Self-checking testbench for the multipole acceptance core: directed and random source nodes.
`timescale 1ns / 100ps

module tb;

   localparam int LIST_DEPTH    = 65536;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int RANDOM_PHASES = 12;
   localparam int PHASE_ITEMS   = 94;

   logic                             clock     = 1'b0;
   logic                             reset     = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_stall;
   tmac_pkg::req_type                req_data  = '0;
   logic                             rsp_valid;
   logic                             rsp_stall = 1'b0;
   tmac_pkg::rsp_type                rsp_data;
   logic                             csr_valid = 1'b0;
   logic                             csr_ready;
   logic [tmac_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [31:0]                      csr_wdata = '0;

   // Mirror of the sink registers and the two running counters.
   tmac_pkg::cfg_type sink_cfg;
   logic [16:0]       list_fill;
   logic [31:0]       interaction_sum;

   // Verdicts owed by the core, oldest first.
   tmac_pkg::rsp_type pending_verdicts[$];
   tmac_pkg::rsp_type due_verdict;

   bit          gaps_on;
   int          error_count = 0;
   int          cycle_count = 0;
   int          n_accept = 0, n_split_source = 0, n_split_sink = 0;
   int          n_body_split = 0, n_overflow = 0, n_saturated = 0;

   tree_multipole_acceptance_core #(
      .LIST_DEPTH (LIST_DEPTH),
      .COORD_WIDTH(32)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Squared distance along one axis, exact, from the signed Q16.16 difference.
   function automatic logic [67:0] axis_square(logic [31:0] a, logic [31:0] b);
      logic signed [32:0] d;
      logic [32:0]        mag;
      d   = $signed({a[31], a}) - $signed({b[31], b});
      mag = d[32] ? 33'(-d) : 33'(d);
      return {35'b0, mag} * {35'b0, mag};
   endfunction

   // Works out the verdict for one source node and advances the counters.
   function automatic tmac_pkg::rsp_type judge_node(tmac_pkg::req_type n);
      tmac_pkg::rsp_type v;
      logic [67:0]       dist2;
      logic [63:0]       r;
      logic [63:0]       rb;
      logic [32:0]       total;
      v = '0;
      if (n.first_of_batch) begin
         list_fill       = sink_cfg.base_list_count;
         interaction_sum = sink_cfg.base_interactions;
      end
      dist2 = axis_square(n.source_x, sink_cfg.sink_x) + axis_square(n.source_y, sink_cfg.sink_y)
            + axis_square(n.source_z, sink_cfg.sink_z);
      r  = 64'(n.source_rcrit);
      rb = r + 64'(sink_cfg.sink_extent);

      if (!sink_cfg.test_mode) begin
         // Plain test: only a body sink can be tested against a cell.
         if (!sink_cfg.sink_is_body)
            v.decision = tmac_pkg::DEC_SPLIT_SINK;
         else if (!n.source_is_cell)
            v.decision = tmac_pkg::DEC_ACCEPT;
         else if (dist2 < {4'b0, r * r})
            v.decision = tmac_pkg::DEC_SPLIT_SOURCE;
         else
            v.decision = tmac_pkg::DEC_ACCEPT;
      end else begin
         // Dual test with the sink extent folded into the radius.
         if (!n.source_is_cell || dist2 > {4'b0, rb * rb}) begin
            v.decision = tmac_pkg::DEC_ACCEPT;
         end else if ((64'(sink_cfg.sink_extent) << 2) > rb) begin
            v.decision = tmac_pkg::DEC_SPLIT_SINK;
            if (sink_cfg.sink_is_body)
               v.fault = tmac_pkg::FAULT_BODY_SPLIT;
         end else begin
            v.decision = tmac_pkg::DEC_SPLIT_SOURCE;
         end
      end

      // Append to the list unless it is full; the total saturates.
      if (v.decision == tmac_pkg::DEC_ACCEPT) begin
         if (list_fill >= LIST_DEPTH) begin
            v.fault = tmac_pkg::FAULT_OVERFLOW;
         end else begin
            total = {1'b0, interaction_sum}
                  + (n.source_is_cell ? 33'(n.source_daughters) : 33'd1);
            v.list_slot     = list_fill[15:0];
            v.entry_mass    = n.source_mass;
            v.entry_x       = n.source_x;
            v.entry_y       = n.source_y;
            v.entry_z       = n.source_z;
            list_fill       = list_fill + 17'd1;
            interaction_sum = total[32] ? 32'hFFFF_FFFF : total[31:0];
         end
      end
      v.list_count        = list_fill;
      v.interaction_total = interaction_sum;
      return v;
   endfunction

   function automatic tmac_pkg::req_type node(logic first, logic is_cell, logic [31:0] mass,
                                              logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                              logic [30:0] rcrit, logic [23:0] daughters);
      tmac_pkg::req_type n;
      n.first_of_batch   = first;
      n.source_is_cell   = is_cell;
      n.source_mass      = mass;
      n.source_x         = x;
      n.source_y         = y;
      n.source_z         = z;
      n.source_rcrit     = rcrit;
      n.source_daughters = daughters;
      return n;
   endfunction

   // Signed offset with magnitude at most 2**sh.
   function automatic logic [31:0] jitter(int sh);
      logic signed [31:0] r;
      r = $urandom;
      return r >>> (31 - sh);
   endfunction

   // Source node placed near the sink on the scale of its own radius, or anywhere.
   function automatic tmac_pkg::req_type random_node(logic first);
      tmac_pkg::req_type n;
      int                k;
      int                sh;
      n.first_of_batch   = first | ($urandom_range(0, 40) == 0);
      n.source_is_cell   = ($urandom_range(0, 3) != 0);
      n.source_mass      = $urandom;
      n.source_daughters = ($urandom_range(0, 9) == 0) ? 24'($urandom)
                                                        : 24'($urandom_range(1, 64));
      if ($urandom_range(0, 4) == 0) begin
         n.source_x     = $urandom;
         n.source_y     = $urandom;
         n.source_z     = $urandom;
         n.source_rcrit = 31'($urandom);
      end else begin
         k  = $urandom_range(0, 30);
         sh = k + int'($urandom_range(0, 3)) - 2;
         if (sh < 0)
            sh = 0;
         if (sh > 31)
            sh = 31;
         n.source_rcrit = 31'($urandom) >> (30 - k);
         n.source_x     = sink_cfg.sink_x + jitter(sh);
         n.source_y     = sink_cfg.sink_y + jitter(sh);
         n.source_z     = sink_cfg.sink_z + jitter(sh);
      end
      return n;
   endfunction

   // Sends one source node beat after an optional gap and books its verdict.
   task automatic send_node(tmac_pkg::req_type n);
      int gap;
      tmac_pkg::rsp_type v;
      if (gaps_on && $urandom_range(0, 2) == 0)
         gap = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      else
         gap = 0;
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= n;
      do @(posedge clock); while (req_stall);
      v = judge_node(n);
      pending_verdicts.push_back(v);
      if (v.fault == tmac_pkg::FAULT_OVERFLOW)
         n_overflow++;
      else if (v.decision == tmac_pkg::DEC_ACCEPT)
         n_accept++;
      else if (v.decision == tmac_pkg::DEC_SPLIT_SOURCE)
         n_split_source++;
      else
         n_split_sink++;
      if (v.fault == tmac_pkg::FAULT_BODY_SPLIT)
         n_body_split++;
      if (v.interaction_total == 32'hFFFF_FFFF)
         n_saturated++;
   endtask

   // Stops the source stream and waits until every verdict has come back.
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_verdicts.size() != 0)
         @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_reg(logic [tmac_pkg::CSR_INDEX_W-1:0] idx, logic [31:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         tmac_pkg::CSR_SINK_X:            sink_cfg.sink_x            = value;
         tmac_pkg::CSR_SINK_Y:            sink_cfg.sink_y            = value;
         tmac_pkg::CSR_SINK_Z:            sink_cfg.sink_z            = value;
         tmac_pkg::CSR_SINK_EXTENT:       sink_cfg.sink_extent       = value[30:0];
         tmac_pkg::CSR_SINK_IS_BODY:      sink_cfg.sink_is_body      = value[0];
         tmac_pkg::CSR_TEST_MODE:         sink_cfg.test_mode         = value[0];
         tmac_pkg::CSR_BASE_LIST_COUNT:   sink_cfg.base_list_count   = value[16:0];
         tmac_pkg::CSR_BASE_INTERACTIONS: sink_cfg.base_interactions = value;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic load_registers(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                 logic [31:0] extent, logic [31:0] body, logic [31:0] mode,
                                 logic [31:0] base_count, logic [31:0] base_total);
      write_reg(tmac_pkg::CSR_SINK_X, x);
      write_reg(tmac_pkg::CSR_SINK_Y, y);
      write_reg(tmac_pkg::CSR_SINK_Z, z);
      write_reg(tmac_pkg::CSR_SINK_EXTENT, extent);
      write_reg(tmac_pkg::CSR_SINK_IS_BODY, body);
      write_reg(tmac_pkg::CSR_TEST_MODE, mode);
      write_reg(tmac_pkg::CSR_BASE_LIST_COUNT, base_count);
      write_reg(tmac_pkg::CSR_BASE_INTERACTIONS, base_total);
   endtask

   // Reset values: dual test, sink at the origin with no extent.
   task automatic test_reset_defaults();
      send_node(node(1, 0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                     31'h7FFF_FFFF, 24'hFF_FFFF));
      send_node(node(0, 1, 32'h0001_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                     31'd1, 24'hFF_FFFF));
      // A cell with no daughters adds nothing to the total.
      send_node(node(0, 1, 32'd1, 32'd1, 32'd0, 32'd0, 31'd0, 24'd0));
      send_node(node(0, 1, 32'd5, 32'd0, 32'd0, 32'd0, 31'd0, 24'd3));
      drain();
   endtask

   // Plain rcrit test, including the tie at exactly rcrit.
   task automatic test_plain_rcrit();
      load_registers(0, 0, 0, 0, 0, 0, 0, 0);
      send_node(node(1, 1, 32'd7, 32'd10, 32'd10, 32'd10, 31'd1, 24'd4));
      drain();
      load_registers(32'h0064_0000, 32'hFFFB_0000, 0, 0, 1, 0, 0, 0);
      send_node(node(1, 0, 32'h0002_0000, 32'd0, 32'd0, 32'd0, 31'd0, 24'd9));
      send_node(node(0, 1, 32'h0003_0000, 32'h0069_0000, 32'hFFFB_0000, 32'd0,
                     31'h0005_0000, 24'd6));
      send_node(node(0, 1, 32'h0003_0000, 32'h0068_FFFF, 32'hFFFB_0000, 32'd0,
                     31'h0005_0000, 24'd6));
      send_node(node(0, 1, 32'd11, 32'h0064_0003, 32'hFFFB_0004, 32'd0, 31'd5, 24'd2));
      send_node(node(0, 1, 32'd11, 32'h0064_0003, 32'hFFFB_0004, 32'd0, 31'd6, 24'd2));
      drain();
      // Opposite corners: the sum of squares carries past 64 bits.
      load_registers(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 1, 0, 0, 0);
      send_node(node(1, 1, 32'd3, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                     31'h7FFF_FFFF, 24'd1));
      drain();
   endtask

   // Dual test: tie at rcrit plus extent, split sink, and a body sink that must split.
   task automatic test_dual_rcrit();
      load_registers(0, 0, 0, 10, 0, 1, 0, 0);
      send_node(node(1, 1, 32'd1, 32'd40, 32'd0, 32'd0, 31'd30, 24'd2));
      send_node(node(0, 1, 32'd1, 32'd41, 32'd0, 32'd0, 31'd30, 24'd2));
      send_node(node(0, 1, 32'd1, 32'd30, 32'd0, 32'd0, 31'd20, 24'd2));
      send_node(node(0, 0, 32'd1, 32'd0, 32'd0, 32'd0, 31'd0, 24'd0));
      drain();
      load_registers(0, 0, 0, 10, 1, 1, 0, 0);
      send_node(node(1, 1, 32'd1, 32'd30, 32'd0, 32'd0, 31'd20, 24'd2));
      drain();
      load_registers(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1, 1, 0, 0);
      send_node(node(1, 1, 32'd8, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                     31'h7FFF_FFFF, 24'd5));
      send_node(node(0, 1, 32'd8, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'd0, 24'd5));
      drain();
   endtask

   // The last free slot, then a full list, then a base fill far past the depth.
   task automatic test_list_overflow();
      load_registers(0, 0, 0, 0, 0, 1, 32'd65535, 32'd7);
      send_node(node(1, 0, 32'd2, 32'd1, 32'd2, 32'd3, 31'd0, 24'd1));
      send_node(node(0, 0, 32'd2, 32'd1, 32'd2, 32'd3, 31'd0, 24'd1));
      drain();
      load_registers(0, 0, 0, 0, 0, 1, 32'h0001_FFFF, 32'd7);
      send_node(node(1, 0, 32'd2, 32'd1, 32'd2, 32'd3, 31'd0, 24'd1));
      drain();
   endtask

   // The interaction total stops at its maximum.
   task automatic test_total_saturation();
      load_registers(0, 0, 0, 0, 0, 1, 0, 32'hFFFF_FFF0);
      send_node(node(1, 1, 32'd4, 32'd100, 32'd0, 32'd0, 31'd1, 24'hFF_FFFF));
      send_node(node(0, 0, 32'd4, 32'd100, 32'd0, 32'd0, 31'd1, 24'd1));
      drain();
   endtask

   // Phases of random nodes, each under a fresh sink and batch setting.
   task automatic test_random_traffic();
      int          p;
      int          i;
      logic [31:0] ext;
      logic [31:0] base_count;
      logic [31:0] base_total;
      for (p = 0; p < RANDOM_PHASES; p++) begin
         drain();
         gaps_on = (p % 3 != 1);
         if (p == 0) begin
            load_registers(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, 0, 0);
         end else if (p == 1) begin
            load_registers(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 1,
                           32'd65500, 32'hFFFF_FFFF);
         end else begin
            // Unused upper bits of the narrow registers carry junk.
            ext = ($urandom_range(0, 5) == 0) ? 32'd0 : 32'($urandom) >> $urandom_range(1, 31);
            ext[31] = 1'($urandom);
            case ($urandom_range(0, 3))
               0:       base_count = $urandom_range(0, 1000);
               1:       base_count = 65536 - $urandom_range(0, 60);
               2:       base_count = 32'($urandom) & 32'h0001_FFFF;
               default: base_count = 0;
            endcase
            base_count[31:17] = 15'($urandom);
            case ($urandom_range(0, 3))
               0:       base_total = 32'hFFFF_FFFF - $urandom_range(0, 5000);
               1:       base_total = $urandom_range(0, 1000);
               default: base_total = $urandom;
            endcase
            load_registers($urandom, $urandom, $urandom, ext,
                           {31'($urandom), 1'($urandom)}, {31'($urandom), 1'($urandom)},
                           base_count, base_total);
         end
         for (i = 0; i < PHASE_ITEMS; i++)
            send_node(random_node(i == 0));
      end
      drain();
   endtask

   // Receiver stalls: short bursts, a few long ones, and long stall-free stretches.
   initial begin
      int run;
      while (reset)
         @(negedge clock);
      forever begin
         run = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 12);
         repeat (run) @(negedge clock);
         rsp_stall <= 1'b1;
         run = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
         repeat (run) @(negedge clock);
         rsp_stall <= 1'b0;
      end
   end

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%08h, got 0x%08h", name, want, got);
         error_count++;
      end
   endtask

   // Each result beat is compared with the oldest verdict owed.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_verdicts.size() == 0) begin
            $error("result beat with no source node outstanding");
            error_count++;
         end else begin
            due_verdict = pending_verdicts.pop_front();
            check_field("decision", due_verdict.decision, rsp_data.decision);
            check_field("list_slot", due_verdict.list_slot, rsp_data.list_slot);
            check_field("entry_mass", due_verdict.entry_mass, rsp_data.entry_mass);
            check_field("entry_x", due_verdict.entry_x, rsp_data.entry_x);
            check_field("entry_y", due_verdict.entry_y, rsp_data.entry_y);
            check_field("entry_z", due_verdict.entry_z, rsp_data.entry_z);
            check_field("list_count", due_verdict.list_count, rsp_data.list_count);
            check_field("interaction_total", due_verdict.interaction_total,
                        rsp_data.interaction_total);
            check_field("fault", due_verdict.fault, rsp_data.fault);
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      sink_cfg           = '0;
      sink_cfg.test_mode = 1'b1;
      list_fill          = '0;
      interaction_sum    = '0;
      gaps_on            = 1'b1;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_plain_rcrit();
      test_dual_rcrit();
      test_list_overflow();
      test_total_saturation();
      test_random_traffic();

      $display("Checked %0d source nodes: %0d accepted, %0d split source, %0d split sink.",
               n_accept + n_split_source + n_split_sink + n_overflow, n_accept,
               n_split_source, n_split_sink);
      $display("Faults seen: %0d body sink splits, %0d list overflows; %0d saturated totals.",
               n_body_split, n_overflow, n_saturated);
      if (error_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

/* filelist.f */
rtl/tmac_pkg.sv
rtl/tmac_front.sv
rtl/tmac_queue.sv
rtl/tmac_back.sv
rtl/tree_multipole_acceptance_core.sv
dv/tb.sv
